@@ rtl/ihist_pkg.sv @@
// Shared constants, types and word layouts for the interarrival histogram core.
package ihist_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_NUM_CHANNELS = 4;
    localparam int DEF_NUM_HOURS    = 24;
    localparam int DEF_NUM_BINS     = 100;
    localparam int DEF_COUNT_WIDTH  = 32;

    // Field widths fixed by the word layouts.
    localparam int TIME_W   = 37;
    localparam int CHAN_W   = 2;
    localparam int PW_W     = 16;
    localparam int HOUR_W   = 5;
    localparam int BINF_W   = 7;
    localparam int OUT_CNT_W = 32;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 3;

    // Time constants in microseconds.
    localparam logic [TIME_W-1:0] US_PER_HOUR = 37'd3600000000;
    localparam logic [TIME_W-1:0] SPAN_US     = 37'd6000000;

    // A difference below the span fits in this many bits.
    localparam int DSMALL_W = 23;

    // The span is split as 2^PRE_SHIFT * DIV_D so the bin division becomes a
    // shift followed by a reciprocal multiply for the division by the 16-bit DIV_D.
    localparam int PRE_SHIFT = 7;
    localparam int DIV_D     = 46875;
    localparam int DIV_D_W   = 16;

    // Depth of the result queue; must exceed the number of pipeline stages.
    localparam int OQ_DEPTH = 8;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    typedef struct packed {
        logic valid;
        logic mode;
        logic hit;
        logic counted;
        logic neg;
        logic over;
        logic ood;
        logic rd_ok;
    } item_ctl_t;

    typedef struct packed {
        logic                  counted;
        logic [HOUR_W-1:0]     hour_index;
        logic [BINF_W-1:0]     bin_index;
        logic                  negative_dt;
        logic                  out_of_day;
        logic [OUT_CNT_W-1:0]  bin_count;
        logic [OUT_CNT_W-1:0]  negative_total;
    } res_t;

endpackage

@@ rtl/ihist_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read.
module ihist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/ihist_front.sv @@
// Front stage: pulse filter, per-channel last-time update and negative counter.
module ihist_front #(
    parameter int NUM_CHANNELS = ihist_pkg::DEF_NUM_CHANNELS,
    parameter int NUM_HOURS    = ihist_pkg::DEF_NUM_HOURS,
    parameter int NUM_BINS     = ihist_pkg::DEF_NUM_BINS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               take,
    input  logic                               mode,
    input  logic [ihist_pkg::TIME_W-1:0]       event_time_us,
    input  logic [ihist_pkg::CHAN_W-1:0]       channel,
    input  logic [ihist_pkg::PW_W-1:0]         pulse_width,
    input  logic [ihist_pkg::HOUR_W-1:0]       read_hour,
    input  logic [ihist_pkg::CHAN_W-1:0]       read_channel,
    input  logic [ihist_pkg::BINF_W-1:0]       read_bin,
    input  logic [ihist_pkg::PW_W-1:0]         width_cut,
    output ihist_pkg::item_ctl_t               ctl_o,
    output logic [ihist_pkg::TIME_W-1:0]       time_o,
    output logic [ihist_pkg::DSMALL_W-1:0]     dsmall_o,
    output logic [ihist_pkg::CHAN_W-1:0]       ch_o,
    output logic [ihist_pkg::HOUR_W-1:0]       rh_o,
    output logic [ihist_pkg::CHAN_W-1:0]       rc_o,
    output logic [ihist_pkg::BINF_W-1:0]       rb_o,
    output logic [ihist_pkg::OUT_CNT_W-1:0]    negtot_o
);
    import ihist_pkg::*;

    localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [TIME_W-1:0] DAY_US = TIME_W'(64'(NUM_HOURS) * 64'(US_PER_HOUR));

    logic [TIME_W-1:0]    last_reg [NUM_CHANNELS];
    logic [OUT_CNT_W-1:0] negcnt_reg;
    logic [OUT_CNT_W-1:0] negcnt_next;
    item_ctl_t            ctl_reg;
    item_ctl_t            ctl_next;

    logic [CH_AW-1:0]     ch_idx;
    logic                 ch_ok;
    logic                 kept;
    logic [TIME_W-1:0]    prev_time;
    logic [TIME_W:0]      delta;

    assign ch_idx = CH_AW'(channel);
    assign ch_ok  = 32'(channel) < NUM_CHANNELS;
    assign kept   = !mode && (pulse_width > width_cut) && ch_ok;
    assign prev_time = ch_ok ? last_reg[ch_idx] : '0;
    assign delta  = {1'b0, event_time_us} - {1'b0, prev_time};

    always_comb
    begin
        ctl_next.valid   = take;
        ctl_next.mode    = mode;
        ctl_next.ood     = kept && (event_time_us > DAY_US);
        ctl_next.hit     = kept && !ctl_next.ood;
        ctl_next.counted = ctl_next.hit && (prev_time != '0);
        ctl_next.neg     = ctl_next.counted && delta[TIME_W];
        ctl_next.over    = !delta[TIME_W] && (delta[TIME_W-1:0] >= SPAN_US);
        ctl_next.rd_ok   = mode && (32'(read_hour) < NUM_HOURS)
                           && (32'(read_channel) < NUM_CHANNELS)
                           && (32'(read_bin) < NUM_BINS + 2);
    end

    // The negative count saturates at all ones.
    always_comb
    begin
        negcnt_next = negcnt_reg;
        if (take && ctl_next.neg && (negcnt_reg != '1))
        begin
            negcnt_next = negcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                last_reg[i] <= '0;
            end
            negcnt_reg <= '0;
            ctl_reg    <= '0;
        end
        else
        begin
            if (take && ctl_next.hit)
            begin
                last_reg[ch_idx] <= event_time_us;
            end
            negcnt_reg <= negcnt_next;
            ctl_reg    <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_o   <= event_time_us;
        dsmall_o <= delta[DSMALL_W-1:0];
        ch_o     <= channel;
        rh_o     <= read_hour;
        rc_o     <= read_channel;
        rb_o     <= read_bin;
        negtot_o <= negcnt_next;
    end

    assign ctl_o = ctl_reg;

endmodule

@@ rtl/ihist_binner.sv @@
// Hour lookup and three-stage constant division of the time difference into a bin.
module ihist_binner #(
    parameter int NUM_HOURS = ihist_pkg::DEF_NUM_HOURS,
    parameter int NUM_BINS  = ihist_pkg::DEF_NUM_BINS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ihist_pkg::item_ctl_t                   ctl_i,
    input  logic [ihist_pkg::TIME_W-1:0]           time_i,
    input  logic [ihist_pkg::DSMALL_W-1:0]         dsmall_i,
    input  logic [ihist_pkg::CHAN_W-1:0]           ch_i,
    input  logic [ihist_pkg::HOUR_W-1:0]           rh_i,
    input  logic [ihist_pkg::CHAN_W-1:0]           rc_i,
    input  logic [ihist_pkg::BINF_W-1:0]           rb_i,
    input  logic [ihist_pkg::OUT_CNT_W-1:0]        negtot_i,
    output ihist_pkg::item_ctl_t                   ctl_o,
    output logic [ihist_pkg::HOUR_W-1:0]           hour_o,
    output logic [ihist_pkg::CHAN_W-1:0]           ch_o,
    output logic [$clog2(NUM_BINS + 2)-1:0]        bin_sel_o,
    output logic [ihist_pkg::BINF_W-1:0]           bin_out_o,
    output logic [ihist_pkg::OUT_CNT_W-1:0]        negtot_o
);
    import ihist_pkg::*;

    localparam int BW    = $clog2(NUM_BINS + 2);
    localparam int NBW   = $clog2(NUM_BINS + 1);
    localparam int PW    = DSMALL_W + NBW;
    localparam int XW    = $clog2(DIV_D * NUM_BINS);
    localparam longint unsigned RECIP = (64'd1 << XW) / 64'(DIV_D);
    localparam int MW    = $clog2(RECIP + 1);
    localparam int QW    = $clog2(NUM_BINS);

    // Stage 1: hour and the pre-shifted scaled difference.
    item_ctl_t            s1_ctl_reg;
    logic [HOUR_W-1:0]    s1_hour_reg;
    logic [CHAN_W-1:0]    s1_ch_reg;
    logic [BINF_W-1:0]    s1_rb_reg;
    logic [OUT_CNT_W-1:0] s1_negtot_reg;
    logic [XW-1:0]        s1_x_reg;

    // Stage 2: quotient estimate.
    item_ctl_t            s2_ctl_reg;
    logic [HOUR_W-1:0]    s2_hour_reg;
    logic [CHAN_W-1:0]    s2_ch_reg;
    logic [BINF_W-1:0]    s2_rb_reg;
    logic [OUT_CNT_W-1:0] s2_negtot_reg;
    logic [XW-1:0]        s2_x_reg;
    logic [QW-1:0]        s2_q0_reg;

    // Stage 3: final bin.
    item_ctl_t            s3_ctl_reg;
    logic [HOUR_W-1:0]    s3_hour_reg;
    logic [CHAN_W-1:0]    s3_ch_reg;
    logic [BW-1:0]        s3_bin_reg;
    logic [BINF_W-1:0]    s3_bout_reg;
    logic [OUT_CNT_W-1:0] s3_negtot_reg;

    logic [NUM_HOURS-1:0] past_hour;
    logic [HOUR_W-1:0]    hour_calc;
    logic [HOUR_W-1:0]    s1_hour_next;
    logic [CHAN_W-1:0]    s1_ch_next;
    logic [PW-1:0]        scaled;
    logic [XW+MW-1:0]     recip_prod;
    logic [QW+DIV_D_W-1:0] q0_times_d;
    logic [XW-1:0]        rem;
    logic [QW-1:0]        q_fix;
    logic [BW-1:0]        bin_next;
    logic [BINF_W-1:0]    bout_next;

    // An exact hour boundary belongs to the earlier hour, hence the strict compare.
    always_comb
    begin
        past_hour = '0;
        for (int k = 1; k < NUM_HOURS; k++)
        begin
            past_hour[k] = time_i > TIME_W'(64'(k) * 64'(US_PER_HOUR));
        end
    end

    assign hour_calc = HOUR_W'($countones(past_hour));

    always_comb
    begin
        if (ctl_i.mode)
        begin
            s1_hour_next = rh_i;
            s1_ch_next   = rc_i;
        end
        else
        begin
            s1_hour_next = ctl_i.hit ? hour_calc : '0;
            s1_ch_next   = ch_i;
        end
    end

    assign scaled     = PW'(dsmall_i) * PW'(NUM_BINS);
    assign recip_prod = (XW + MW)'(s1_x_reg) * (XW + MW)'(RECIP);
    assign q0_times_d = (QW + DIV_D_W)'(s2_q0_reg) * (QW + DIV_D_W)'(DIV_D);
    assign rem        = s2_x_reg - XW'(q0_times_d);
    assign q_fix      = (rem >= XW'(DIV_D)) ? s2_q0_reg + 1'b1 : s2_q0_reg;

    always_comb
    begin
        if (s2_ctl_reg.mode)
        begin
            bin_next  = BW'(s2_rb_reg);
            bout_next = s2_rb_reg;
        end
        else
        begin
            if (s2_ctl_reg.neg)
            begin
                bin_next = '0;
            end
            else if (s2_ctl_reg.over)
            begin
                bin_next = BW'(NUM_BINS + 1);
            end
            else
            begin
                bin_next = BW'(q_fix) + 1'b1;
            end
            bout_next = s2_ctl_reg.counted ? BINF_W'(bin_next) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
        end
        else
        begin
            s1_ctl_reg <= ctl_i;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_hour_reg   <= s1_hour_next;
        s1_ch_reg     <= s1_ch_next;
        s1_rb_reg     <= rb_i;
        s1_negtot_reg <= negtot_i;
        s1_x_reg      <= XW'(scaled >> PRE_SHIFT);

        s2_hour_reg   <= s1_hour_reg;
        s2_ch_reg     <= s1_ch_reg;
        s2_rb_reg     <= s1_rb_reg;
        s2_negtot_reg <= s1_negtot_reg;
        s2_x_reg      <= s1_x_reg;
        s2_q0_reg     <= QW'(recip_prod >> XW);

        s3_hour_reg   <= s2_hour_reg;
        s3_ch_reg     <= s2_ch_reg;
        s3_bin_reg    <= bin_next;
        s3_bout_reg   <= bout_next;
        s3_negtot_reg <= s2_negtot_reg;
    end

    assign ctl_o     = s3_ctl_reg;
    assign hour_o    = s3_hour_reg;
    assign ch_o      = s3_ch_reg;
    assign bin_sel_o = s3_bin_reg;
    assign bin_out_o = s3_bout_reg;
    assign negtot_o  = s3_negtot_reg;

endmodule

@@ rtl/ihist_count.sv @@
// Histogram memory with read-modify-write, write forwarding and the clearing pass.
module ihist_count #(
    parameter int NUM_CHANNELS = ihist_pkg::DEF_NUM_CHANNELS,
    parameter int NUM_HOURS    = ihist_pkg::DEF_NUM_HOURS,
    parameter int NUM_BINS     = ihist_pkg::DEF_NUM_BINS,
    parameter int COUNT_WIDTH  = ihist_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ihist_pkg::item_ctl_t                ctl_i,
    input  logic [ihist_pkg::HOUR_W-1:0]        hour_i,
    input  logic [ihist_pkg::CHAN_W-1:0]        ch_i,
    input  logic [$clog2(NUM_BINS + 2)-1:0]     bin_sel_i,
    input  logic [ihist_pkg::BINF_W-1:0]        bin_out_i,
    input  logic [ihist_pkg::OUT_CNT_W-1:0]     negtot_i,
    output logic                                res_valid_o,
    output ihist_pkg::res_t                     res_o,
    output logic                                clear_busy_o
);
    import ihist_pkg::*;

    localparam int BT    = NUM_BINS + 2;
    localparam int CELLS = NUM_HOURS * NUM_CHANNELS * BT;
    localparam int AW    = $clog2(CELLS);

    item_ctl_t            c1_ctl_reg;
    logic [HOUR_W-1:0]    c1_hour_reg;
    logic [BINF_W-1:0]    c1_bout_reg;
    logic [OUT_CNT_W-1:0] c1_negtot_reg;
    logic [AW-1:0]        c1_addr_reg;

    logic                 fwd_valid_reg;
    logic [AW-1:0]        fwd_addr_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;

    logic                 clearing_reg;
    logic [AW-1:0]        clr_addr_reg;

    logic [AW-1:0]        rd_addr;
    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] inc_count;
    logic                 upd;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;

    assign rd_addr = AW'(hour_i) * AW'(NUM_CHANNELS * BT) + AW'(ch_i) * AW'(BT)
                     + AW'(bin_sel_i);

    // The entry written in the previous cycle is not yet visible in the read data.
    assign cur_count = (fwd_valid_reg && (fwd_addr_reg == c1_addr_reg)) ? fwd_data_reg
                                                                          : ram_rdata;
    assign inc_count = (cur_count == '1) ? cur_count : cur_count + 1'b1;
    assign upd       = c1_ctl_reg.valid && c1_ctl_reg.counted;

    always_comb
    begin
        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = upd;
            ram_waddr = c1_addr_reg;
            ram_wdata = inc_count;
        end
    end

    ihist_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_ctl_reg    <= '0;
            fwd_valid_reg <= 1'b0;
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
        end
        else
        begin
            c1_ctl_reg <= ctl_i;
            if (upd && !clearing_reg)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(CELLS - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c1_hour_reg   <= hour_i;
        c1_bout_reg   <= bin_out_i;
        c1_negtot_reg <= negtot_i;
        c1_addr_reg   <= rd_addr;
        if (upd)
        begin
            fwd_addr_reg <= c1_addr_reg;
            fwd_data_reg <= inc_count;
        end
    end

    always_comb
    begin
        res_o.counted        = c1_ctl_reg.counted;
        res_o.hour_index     = c1_hour_reg;
        res_o.bin_index      = c1_bout_reg;
        res_o.negative_dt    = c1_ctl_reg.neg;
        res_o.out_of_day     = c1_ctl_reg.ood;
        res_o.negative_total = c1_negtot_reg;
        if (c1_ctl_reg.counted)
        begin
            res_o.bin_count = OUT_CNT_W'(inc_count);
        end
        else if (c1_ctl_reg.rd_ok)
        begin
            res_o.bin_count = OUT_CNT_W'(cur_count);
        end
        else
        begin
            res_o.bin_count = '0;
        end
    end

    assign res_valid_o  = c1_ctl_reg.valid;
    assign clear_busy_o = clearing_reg;

endmodule

@@ rtl/per_channel_interarrival_histogram_core.sv @@
// Top level of the per-channel interarrival histogram core.
//
//  Channel   Direction  Handshake           Content of one word
//  --------  ---------  ------------------  ------------------------------------------
//  cfg       in         cfg_valid/ready     width_cut (16 bit)
//  s_axis    in         s_tvalid/tready     pulse event or bin read request
//  m_axis    out        m_tvalid/tready     one result per accepted input word
//
//  One input word is accepted per clock cycle in steady state. Its result word is
//  valid on m_axis after the front stage register, the three divider stages, the
//  memory read and the result queue write. The histogram memory has one read and
//  one write port; an update in one cycle is forwarded to a read of the same bin in
//  the next, so no interlock is needed. After reset the memory is cleared one bin
//  per cycle, all NUM_HOURS * NUM_CHANNELS * (NUM_BINS + 2) bins (9792 with the
//  defaults); s_tready stays low until then, while configuration writes are taken
//  at once. Results collect in an eight-word queue. Input words are taken while
//  fewer than eight words are in flight or queued, so a stalled output stops the
//  input once eight words are outstanding, and no stage ever stalls.
module per_channel_interarrival_histogram_core #(
    parameter int NUM_CHANNELS = ihist_pkg::DEF_NUM_CHANNELS,
    parameter int NUM_HOURS    = ihist_pkg::DEF_NUM_HOURS,
    parameter int NUM_BINS     = ihist_pkg::DEF_NUM_BINS,
    parameter int COUNT_WIDTH  = ihist_pkg::DEF_COUNT_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ihist_pkg::PW_W-1:0]         cfg_data,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    // event_time_us[36:0], channel[38:37], pulse_width[54:39], read_hour[59:55],
    // read_channel[61:60], read_bin[68:62], zero pad[71:69]
    input  logic [ihist_pkg::S_TDATA_W-1:0]    s_tdata,
    // mode: 0 pulse event, 1 bin read
    input  logic                               s_tuser,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // hour_index[4:0], bin_index[11:5], bin_count[43:12], negative_total[75:44],
    // zero pad[79:76]
    output logic [ihist_pkg::M_TDATA_W-1:0]    m_tdata,
    // counted[0], negative_dt[1], out_of_day[2]
    output logic [ihist_pkg::M_TUSER_W-1:0]    m_tuser
);
    import ihist_pkg::*;

    localparam int BW    = $clog2(NUM_BINS + 2);
    localparam int OCC_W = $clog2(OQ_DEPTH + 1);

    // Configuration register.
    logic [PW_W-1:0]      width_cut_reg;

    // Front to divider.
    item_ctl_t            f_ctl;
    logic [TIME_W-1:0]    f_time;
    logic [DSMALL_W-1:0]  f_dsmall;
    logic [CHAN_W-1:0]    f_ch;
    logic [HOUR_W-1:0]    f_rh;
    logic [CHAN_W-1:0]    f_rc;
    logic [BINF_W-1:0]    f_rb;
    logic [OUT_CNT_W-1:0] f_negtot;

    // Divider to memory stage.
    item_ctl_t            b_ctl;
    logic [HOUR_W-1:0]    b_hour;
    logic [CHAN_W-1:0]    b_ch;
    logic [BW-1:0]        b_bin_sel;
    logic [BINF_W-1:0]    b_bin_out;
    logic [OUT_CNT_W-1:0] b_negtot;

    // Memory stage to result queue.
    logic                 res_valid;
    res_t                 res;
    logic                 clear_busy;

    // Result queue.
    res_t                 oq_reg [OQ_DEPTH];
    logic [OQ_AW-1:0]     oq_wr_reg;
    logic [OQ_AW-1:0]     oq_rd_reg;
    logic [OCC_W-1:0]     oq_cnt_reg;
    logic [OCC_W-1:0]     oq_cnt_next;
    logic [OCC_W-1:0]     occ_reg;
    logic [OCC_W-1:0]     occ_next;
    res_t                 oq_head;

    logic                 take;
    logic                 pop;

    // Configuration writes are always taken; users must issue them only while idle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cut_reg <= '0;
        end
        else if (cfg_valid)
        begin
            width_cut_reg <= cfg_data;
        end
    end

    // occ_reg counts every word accepted whose result has not left the queue, so
    // the queue can always absorb what is still in the pipeline.
    assign s_tready = !clear_busy && (occ_reg < OCC_W'(OQ_DEPTH));
    assign take     = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    ihist_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_HOURS    (NUM_HOURS),
        .NUM_BINS     (NUM_BINS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .mode          (s_tuser),
        .event_time_us (s_tdata[36:0]),
        .channel       (s_tdata[38:37]),
        .pulse_width   (s_tdata[54:39]),
        .read_hour     (s_tdata[59:55]),
        .read_channel  (s_tdata[61:60]),
        .read_bin      (s_tdata[68:62]),
        .width_cut     (width_cut_reg),
        .ctl_o         (f_ctl),
        .time_o        (f_time),
        .dsmall_o      (f_dsmall),
        .ch_o          (f_ch),
        .rh_o          (f_rh),
        .rc_o          (f_rc),
        .rb_o          (f_rb),
        .negtot_o      (f_negtot)
    );

    ihist_binner #(
        .NUM_HOURS (NUM_HOURS),
        .NUM_BINS  (NUM_BINS)
    ) u_binner (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_i     (f_ctl),
        .time_i    (f_time),
        .dsmall_i  (f_dsmall),
        .ch_i      (f_ch),
        .rh_i      (f_rh),
        .rc_i      (f_rc),
        .rb_i      (f_rb),
        .negtot_i  (f_negtot),
        .ctl_o     (b_ctl),
        .hour_o    (b_hour),
        .ch_o      (b_ch),
        .bin_sel_o (b_bin_sel),
        .bin_out_o (b_bin_out),
        .negtot_o  (b_negtot)
    );

    ihist_count #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_HOURS    (NUM_HOURS),
        .NUM_BINS     (NUM_BINS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_count (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl_i        (b_ctl),
        .hour_i       (b_hour),
        .ch_i         (b_ch),
        .bin_sel_i    (b_bin_sel),
        .bin_out_i    (b_bin_out),
        .negtot_i     (b_negtot),
        .res_valid_o  (res_valid),
        .res_o        (res),
        .clear_busy_o (clear_busy)
    );

    always_comb
    begin
        oq_cnt_next = oq_cnt_reg;
        occ_next    = occ_reg;
        if (res_valid && !pop)
        begin
            oq_cnt_next = oq_cnt_reg + 1'b1;
        end
        else if (!res_valid && pop)
        begin
            oq_cnt_next = oq_cnt_reg - 1'b1;
        end
        if (take && !pop)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (!take && pop)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            if (res_valid)
            begin
                oq_wr_reg <= oq_wr_reg + 1'b1;
            end
            if (pop)
            begin
                oq_rd_reg <= oq_rd_reg + 1'b1;
            end
            oq_cnt_reg <= oq_cnt_next;
            occ_reg    <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            oq_reg[oq_wr_reg] <= res;
        end
    end

    assign oq_head  = oq_reg[oq_rd_reg];
    assign m_tvalid = (oq_cnt_reg != '0);
    assign m_tdata  = {4'b0000, oq_head.negative_total, oq_head.bin_count,
                       oq_head.bin_index, oq_head.hour_index};
    assign m_tuser  = {oq_head.out_of_day, oq_head.negative_dt, oq_head.counted};

    // No word enters the pipeline while the memory is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n) clear_busy |-> !s_tready)
        else $error("input accepted during the clearing pass");

    // A result never arrives at a full queue unless the head leaves in that cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (res_valid && (oq_cnt_reg == OCC_W'(OQ_DEPTH))) |-> pop)
        else $error("result queue overflow");

    // Nothing is in flight when the clearing pass ends.
    assert property (@(posedge clk) disable iff (!rst_n)
                     $fell(clear_busy) |-> ((occ_reg == '0) && (oq_cnt_reg == '0)))
        else $error("words in flight at the end of the clearing pass");

endmodule

@@ bench/per_channel_interarrival_histogram_core_tb.sv @@
// Self-checking testbench for the per-channel interarrival histogram core.
module per_channel_interarrival_histogram_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Histogram geometry, taken from the core's default parameters.
    localparam int NCH    = ihist_pkg::DEF_NUM_CHANNELS;
    localparam int NHR    = ihist_pkg::DEF_NUM_HOURS;
    localparam int NBIN   = ihist_pkg::DEF_NUM_BINS;
    localparam int NBT    = NBIN + 2;
    localparam int NCELLS = NHR * NCH * NBT;

    // Special bins: negative gaps land in the underflow bin, gaps of the full
    // span or longer in the overflow bin.
    localparam int BIN_UNDER = 0;
    localparam int BIN_OVER  = NBIN + 1;

    // Time constants in microseconds.
    localparam longint unsigned HOUR_US = 64'd3_600_000_000;
    localparam longint unsigned DAY_US  = HOUR_US * NHR;
    localparam longint unsigned SPAN_US = 64'd6_000_000;

    // Receiver hold-off used to back the core up until it stops taking input.
    localparam int HOLD_CYCLES = 300;

    // Kind of an input word, carried on s_tuser.
    typedef enum logic {
        MODE_PULSE = 1'b0,
        MODE_READ  = 1'b1
    } mode_e;

    // One input word. The packing puts t_us in the lowest bits, exactly as the
    // core's s_tdata layout expects, with mode above the tdata fields.
    typedef struct packed {
        mode_e       mode;
        logic [6:0]  rd_bin;
        logic [1:0]  rd_chan;
        logic [4:0]  rd_hour;
        logic [15:0] pw;
        logic [1:0]  chan;
        logic [36:0] t_us;
    } req_t;

    // Tracks the histogram state of the core and the results still to come.
    class hist_scoreboard;
        bit [15:0]        cut;
        bit [36:0]        last_t [NCH];
        bit [31:0]        counts [NCELLS];
        bit [31:0]        neg_total;
        ihist_pkg::res_t  awaited_results [$];
        int unsigned      recent_bins [$];
        int               mismatches;
        int               checked;
        int               reads;
        int               counted_hits;
        int               negatives;
        int               dropped;

        function void set_cut(bit [15:0] v);
            cut = v;
        endfunction

        function int unsigned bin_addr(int unsigned h, int unsigned c, int unsigned b);
            return (h * NCH + c) * NBT + b;
        endfunction

        // Applies one accepted word to the histogram copy and returns the
        // result word the core must produce for it.
        function ihist_pkg::res_t histogram_step(req_t w);
            ihist_pkg::res_t  r;
            longint unsigned  tv;
            longint unsigned  prev;
            longint unsigned  hr;
            longint unsigned  d;
            int unsigned      bin;
            int unsigned      idx;
            r  = '0;
            tv = 64'(w.t_us);
            if (w.mode == MODE_READ) begin
                reads++;
                r.hour_index = w.rd_hour;
                r.bin_index  = w.rd_bin;
                if (w.rd_hour < NHR && w.rd_chan < NCH && w.rd_bin < NBT)
                    r.bin_count = counts[bin_addr(32'(w.rd_hour), 32'(w.rd_chan),
                                                  32'(w.rd_bin))];
            end
            else if (w.pw > cut && w.chan < NCH) begin
                if (tv > DAY_US) begin
                    r.out_of_day = 1'b1;
                    dropped++;
                end
                else begin
                    // An exact hour boundary still belongs to the earlier hour.
                    hr = (tv == 0) ? 64'd0 : (tv - 1) / HOUR_US;
                    prev = 64'(last_t[w.chan]);
                    r.hour_index = hr[4:0];
                    // A stored zero means the channel has no previous pulse yet.
                    if (prev != 0) begin
                        if (tv < prev) begin
                            r.negative_dt = 1'b1;
                            negatives++;
                            if (neg_total != '1)
                                neg_total++;
                            bin = BIN_UNDER;
                        end
                        else begin
                            d = tv - prev;
                            if (d >= SPAN_US)
                                bin = BIN_OVER;
                            else
                                bin = 32'(1 + (d * NBIN) / SPAN_US);
                        end
                        idx = bin_addr(32'(hr), 32'(w.chan), bin);
                        if (counts[idx] != '1)
                            counts[idx]++;
                        r.counted   = 1'b1;
                        r.bin_index = 7'(bin);
                        r.bin_count = counts[idx];
                        counted_hits++;
                        recent_bins.push_back(idx);
                        if (recent_bins.size() > 64)
                            void'(recent_bins.pop_front());
                    end
                    last_t[w.chan] = w.t_us;
                end
            end
            r.negative_total = neg_total;
            return r;
        endfunction

        function void note_word(req_t w);
            awaited_results.push_back(histogram_step(w));
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] MISMATCH %s", $realtime, msg);
        endtask

        task compare_field(string name, longint unsigned got, longint unsigned want);
            if (got != want)
                report($sformatf("result %0d %s: got %0d, want %0d", checked, name, got,
                    want));
        endtask

        task check_word(ihist_pkg::res_t got);
            ihist_pkg::res_t exp_r;
            if (awaited_results.size() == 0) begin
                report($sformatf("result word with nothing outstanding: %p", got));
                return;
            end
            exp_r = awaited_results.pop_front();
            checked++;
            compare_field("counted", got.counted, exp_r.counted);
            compare_field("hour_index", got.hour_index, exp_r.hour_index);
            compare_field("bin_index", got.bin_index, exp_r.bin_index);
            compare_field("negative_dt", got.negative_dt, exp_r.negative_dt);
            compare_field("out_of_day", got.out_of_day, exp_r.out_of_day);
            compare_field("bin_count", got.bin_count, exp_r.bin_count);
            compare_field("negative_total", got.negative_total, exp_r.negative_total);
        endtask
    endclass

    // Every input of the core starts at a known value; reset is held from time zero.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // event_time_us, channel, pulse_width, read_hour, read_channel, read_bin, zero pad
    logic [ihist_pkg::S_TDATA_W-1:0] s_tdata = '0;
    // mode
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // hour_index, bin_index, bin_count, negative_total, zero pad
    logic [ihist_pkg::M_TDATA_W-1:0] m_tdata;
    // counted, negative_dt, out_of_day
    logic [ihist_pkg::M_TUSER_W-1:0] m_tuser;

    hist_scoreboard sb = new;

    // Traffic shaping knobs. hold_reqs is only written by the stimulus and
    // hold_seen only by the receiver, so the two never race on one variable.
    bit              src_idle_on = 1'b1;
    bit              sink_idle_on = 1'b1;
    int              hold_reqs = 0;
    int              hold_seen = 0;
    int              hold_left = 0;
    longint unsigned cursor [NCH];
    bit [15:0]       mid_cut;

    per_channel_interarrival_histogram_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Input monitor: at each edge the port values are still the ones from before
    // the edge, so a word seen here with tvalid and tready high was just taken.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_word(req_t'({s_tuser, s_tdata[68:0]}));
    end

    // Output monitor: unpack the result word and hand it to the scoreboard.
    always @(posedge clk)
    begin
        ihist_pkg::res_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got.counted        = m_tuser[0];
            got.negative_dt    = m_tuser[1];
            got.out_of_day     = m_tuser[2];
            got.hour_index     = m_tdata[4:0];
            got.bin_index      = m_tdata[11:5];
            got.bin_count      = m_tdata[43:12];
            got.negative_total = m_tdata[75:44];
            sb.check_word(got);
        end
    end

    // Receiver: stalls about a quarter of the cycles when idling is on, and holds
    // off completely whenever the stimulus asks for a hold.
    initial
    begin
        forever begin
            @(posedge clk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(sink_idle_on && $urandom_range(99) < 25);
        end
    end

    // Global watchdog, far beyond the slowest legal run including the memory
    // clearing pass after reset.
    initial
    begin
        #5_000_000;
        $display("per_channel_interarrival_histogram_core_tb: errors");
        $finish;
    end

    function req_t pulse_word(int unsigned ch, longint unsigned t, int unsigned pw);
        req_t w;
        w = '0;
        w.mode = MODE_PULSE;
        w.chan = 2'(ch);
        w.t_us = 37'(t);
        w.pw   = 16'(pw);
        return w;
    endfunction

    function req_t read_word(int unsigned h, int unsigned c, int unsigned b);
        req_t w;
        w = '0;
        w.mode    = MODE_READ;
        w.rd_hour = 5'(h);
        w.rd_chan = 2'(c);
        w.rd_bin  = 7'(b);
        return w;
    endfunction

    // Random word. Most are pulses that follow a per-channel time cursor, so the
    // gaps spread over all regular bins with some negative gaps, overflow gaps and
    // jumps to other hours. Reads mostly target recently counted bins so they
    // return nonzero counts. The rest is noise over the full field ranges.
    function req_t random_request();
        req_t            w;
        int unsigned     r;
        int unsigned     c;
        longint unsigned t;
        longint unsigned raw;
        w.mode    = MODE_PULSE;
        w.t_us    = 37'({$urandom_range(31), $urandom});
        w.chan    = 2'($urandom_range(3));
        w.pw      = 16'($urandom_range(65535));
        w.rd_hour = 5'($urandom_range(31));
        w.rd_chan = 2'($urandom_range(3));
        w.rd_bin  = 7'($urandom_range(127));
        r = $urandom_range(99);
        if (r < 15) begin
            w.mode = MODE_READ;
            if (sb.recent_bins.size() != 0 && $urandom_range(3) != 0) begin
                c = sb.recent_bins[$urandom_range(sb.recent_bins.size() - 1)];
                w.rd_hour = 5'(c / (NCH * NBT));
                w.rd_chan = 2'((c / NBT) % NCH);
                w.rd_bin  = 7'(c % NBT);
            end
        end
        else if (r >= 20) begin
            c   = 32'(w.chan);
            r   = $urandom_range(99);
            raw = {$urandom, $urandom};
            if (r < 8)
                t = raw % (DAY_US + 1);
            else if (r < 16 && cursor[c] > 3_000_000)
                t = cursor[c] - 64'($urandom_range(3_000_000, 1));
            else
                t = cursor[c] + 64'($urandom_range(6_300_000));
            if (sb.cut != 16'hFFFF && $urandom_range(9) != 0)
                w.pw = 16'($urandom_range(65535, sb.cut + 1));
            w.t_us = 37'(t);
            // Past the end of the day the cursor restarts somewhere in the day.
            if (w.pw > sb.cut)
                cursor[c] = (t > DAY_US) ? raw % DAY_US : t;
        end
        return w;
    endfunction

    // Offers one word, with random idle cycles in front when idling is on, and
    // returns at the edge where the core takes it. tvalid stays high afterwards
    // so back-to-back words need no gap.
    task send_word(req_t w);
        while (src_idle_on && $urandom_range(99) < 25) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, w[68:0]};
        s_tuser  <= w.mode;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task run_random(int n, bit idle_on);
        src_idle_on  = idle_on;
        sink_idle_on = idle_on;
        repeat (n)
            send_word(random_request());
    endtask

    // Stops offering words and waits for every outstanding result, then a few
    // more cycles so the pipeline is certainly empty.
    task wait_drain();
        s_tvalid <= 1'b0;
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task write_cut(logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_cut(v);
        cfg_valid <= 1'b0;
    endtask

    // Directed words with the cut at zero: first pulses, the cut itself, bin
    // edges, overflow, zero and negative gaps, hour and day boundaries, times
    // past the day, and reads inside and outside the histogram.
    task run_directed();
        req_t            dir_q [$];
        longint unsigned t0;
        t0 = 1_000_000;
        dir_q.push_back(read_word(0, 0, BIN_UNDER));
        dir_q.push_back(pulse_word(0, 0, 16'hFFFF));
        dir_q.push_back(pulse_word(0, t0, 1));
        dir_q.push_back(pulse_word(0, t0 + 500, 0));
        dir_q.push_back(pulse_word(0, t0 + 59_999, 100));
        dir_q.push_back(pulse_word(0, t0 + 119_999, 100));
        dir_q.push_back(pulse_word(0, t0 + 6_119_998, 100));
        dir_q.push_back(pulse_word(0, t0 + 12_119_998, 100));
        dir_q.push_back(pulse_word(0, t0 + 12_119_998, 100));
        dir_q.push_back(pulse_word(0, t0, 100));
        dir_q.push_back(pulse_word(1, HOUR_US, 7));
        dir_q.push_back(pulse_word(1, HOUR_US + 1, 7));
        dir_q.push_back(pulse_word(2, DAY_US, 7));
        dir_q.push_back(pulse_word(2, DAY_US + 1, 7));
        dir_q.push_back(pulse_word(3, 37'h1F_FFFF_FFFF, 16'hFFFF));
        dir_q.push_back(pulse_word(3, DAY_US - 1, 7));
        dir_q.push_back(pulse_word(3, DAY_US, 7));
        dir_q.push_back(read_word(0, 0, 1));
        dir_q.push_back(read_word(0, 0, BIN_OVER));
        dir_q.push_back(read_word(0, 0, BIN_UNDER));
        dir_q.push_back(read_word(NHR - 1, 3, 1));
        dir_q.push_back(read_word(31, 3, 127));
        dir_q.push_back(read_word(NHR - 1, 0, NBT));
        dir_q.push_back(read_word(NHR, 1, 5));
        foreach (dir_q[i])
            send_word(dir_q[i]);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // The cut register is taken at once, even while the core still clears
        // its histogram memory with s_tready low.
        write_cut(16'h0000);
        run_directed();
        run_random(330, 1'b1);
        wait_drain();

        // Highest cut: no pulse can pass, only reads and dropped pulses remain.
        write_cut(16'hFFFF);
        run_random(30, 1'b1);
        wait_drain();

        // Middle cut. Halfway through, the receiver holds off while the sender
        // keeps offering words without gaps, so the result queue fills up and
        // the core has to stop taking input.
        mid_cut = 16'($urandom_range(65534, 1));
        write_cut(mid_cut);
        run_random(150, 1'b1);
        hold_reqs++;
        run_random(60, 1'b0);
        run_random(150, 1'b1);
        wait_drain();

        // Cut of one, first a stretch at full rate on both sides.
        write_cut(16'h0001);
        run_random(150, 1'b0);
        run_random(150, 1'b1);
        wait_drain();

        $display("run covered %0d result words: %0d reads, %0d counted pulses,",
            sb.checked, sb.reads, sb.counted_hits);
        $display("%0d negative gaps, %0d pulses past the day, cuts 0, 65535, %0d and 1",
            sb.negatives, sb.dropped, mid_cut);
        if (sb.mismatches == 0)
            $display("per_channel_interarrival_histogram_core_tb: clean");
        else
            $display("per_channel_interarrival_histogram_core_tb: errors");
        $finish;
    end

endmodule
